// ----- hw/rtl/msort_pkg.sv -----
// Package for the merge sorter: the word width and the control and status
// structs that join the sequencer and the datapath. No dependencies.
package msort_pkg;

    localparam int VALUE_W = 32;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_we;   // store an input word in the main store
        logic merge_we;  // store the merged word in the destination store
        logic wr_sel;    // destination store of a merge write: 0 main, 1 merge
        logic rd_sel;    // store that the next read takes from: 0 main, 1 merge
        logic a_live;    // left run still has words
        logic b_live;    // right run still has words
        logic out_load;  // move the read word into the output register
        logic out_last;  // the word loaded is the final one of the set
        logic out_ovf;   // the set lost words at load time
    } t_ms_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic take_left; // merge takes the left head this cycle
        logic out_free;  // output register can take a word this cycle
    } t_ms_stat;

endpackage

// ----- hw/rtl/msort_dp.sv -----
// Datapath of the merge sorter: the two stores, their registered read ports,
// the head compare and the output register. Depends on msort_pkg.
module msort_dp #(
    parameter int AW = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  msort_pkg::t_ms_ctrl             i_ctrl,
    output msort_pkg::t_ms_stat             o_stat,
    input  logic [AW-1:0]                   i_wr_addr,
    input  logic [AW-1:0]                   i_rd_addr_a,
    input  logic [AW-1:0]                   i_rd_addr_b,
    input  logic [msort_pkg::VALUE_W-1:0]   i_in_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [msort_pkg::VALUE_W-1:0]   o_out_value,
    output logic                            o_out_last,
    output logic                            o_out_ovf
);
    import msort_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [VALUE_W-1:0] r_main_store  [DEPTH];
    logic [VALUE_W-1:0] r_merge_store [DEPTH];
    logic [VALUE_W-1:0] r_main_a, r_main_b, r_merge_a, r_merge_b;
    logic               r_sel;
    logic [VALUE_W-1:0] rd_a, rd_b, wr_data;
    logic               we_main, we_merge;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last, r_out_ovf;

    assign rd_a = r_sel ? r_merge_a : r_main_a;
    assign rd_b = r_sel ? r_merge_b : r_main_b;

    // Stable merge: on equal heads the left run wins.
    assign o_stat.take_left = i_ctrl.a_live &&
                              (!i_ctrl.b_live || ($signed(rd_a) <= $signed(rd_b)));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign wr_data  = i_ctrl.load_we ? i_in_value : (o_stat.take_left ? rd_a : rd_b);
    assign we_main  = i_ctrl.load_we || (i_ctrl.merge_we && !i_ctrl.wr_sel);
    assign we_merge = i_ctrl.merge_we && i_ctrl.wr_sel;

    always_ff @(posedge i_clk) begin
        if (we_main) begin
            r_main_store[i_wr_addr] <= wr_data;
        end
        if (we_merge) begin
            r_merge_store[i_wr_addr] <= wr_data;
        end
        r_main_a  <= r_main_store[i_rd_addr_a];
        r_main_b  <= r_main_store[i_rd_addr_b];
        r_merge_a <= r_merge_store[i_rd_addr_a];
        r_merge_b <= r_merge_store[i_rd_addr_b];
        r_sel     <= i_ctrl.rd_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctrl.out_load) begin
            r_out_value <= rd_a;
            r_out_last  <= i_ctrl.out_last;
            r_out_ovf   <= i_ctrl.out_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

// ----- hw/rtl/msort_ctrl.sv -----
// Sequencer of the merge sorter: load counting, bottom-up merge passes and
// the emit pass. Drives msort_dp through msort_pkg command and status structs.
module msort_ctrl #(
    parameter int MAX_ITEMS = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_in_last,
    output msort_pkg::t_ms_ctrl  o_ctrl,
    input  msort_pkg::t_ms_stat  i_stat,
    output logic [AW-1:0]        o_wr_addr,
    output logic [AW-1:0]        o_rd_addr_a,
    output logic [AW-1:0]        o_rd_addr_b
);
    import msort_pkg::*;

    localparam int PW = CW + 2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_MERGE,
        S_EPREP,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic          r_ovf, n_ovf;
    logic          r_par, n_par;
    logic [PW-1:0] r_w, n_w;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_mid, n_mid, r_hi, n_hi;
    logic [CW-1:0] set_n;
    logic [PW-1:0] w2;
    logic          accept, stored;

    function automatic logic [CW-1:0] clip(input logic [PW-1:0] pos,
                                           input logic [CW-1:0] lim);
        logic [PW-1:0] lim_x;
        lim_x = PW'(lim);
        clip  = (pos > lim_x) ? lim : pos[CW-1:0];
    endfunction

    assign o_in_ready = (r_state == S_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign stored     = r_n < CW'(MAX_ITEMS);
    assign set_n      = stored ? r_n + CW'(1) : r_n;
    assign w2         = r_w << 1;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_ovf   = r_ovf;
        n_par   = r_par;
        n_w     = r_w;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;
        o_ctrl  = '0;
        o_ctrl.rd_sel = r_par;
        o_ctrl.wr_sel = !r_par;
        o_ctrl.a_live = r_i < r_mid;
        o_ctrl.b_live = r_j < r_hi;
        o_ctrl.out_ovf = r_ovf;
        o_wr_addr = r_k[AW-1:0];

        case (r_state)
            S_LOAD: begin
                o_wr_addr = r_n[AW-1:0];
                if (accept) begin
                    o_ctrl.load_we = stored;
                    n_n            = set_n;
                    if (!stored) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_par = 1'b0;
                        n_i   = '0;
                        n_w   = PW'(1);
                        n_mid = CW'(1);
                        n_j   = CW'(1);
                        n_hi  = clip(PW'(2), set_n);
                        n_k   = '0;
                        n_state = (set_n == CW'(1)) ? S_EPREP : S_PREP;
                    end
                end
                o_ctrl.rd_sel = n_par;
            end
            S_PREP: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                o_ctrl.merge_we = 1'b1;
                n_k = r_k + CW'(1);
                if (i_stat.take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if (r_k + CW'(1) == r_hi) begin
                    if (r_hi == r_n) begin
                        // End of a pass: the destination becomes the source.
                        n_par = !r_par;
                        n_w   = w2;
                        n_i   = '0;
                        n_k   = '0;
                        n_mid = clip(w2, r_n);
                        n_j   = clip(w2, r_n);
                        n_hi  = clip(w2 << 1, r_n);
                        n_state = (w2 >= PW'(r_n)) ? S_EPREP : S_PREP;
                    end else begin
                        n_i   = r_hi;
                        n_mid = clip(PW'(r_hi) + r_w, r_n);
                        n_j   = clip(PW'(r_hi) + r_w, r_n);
                        n_hi  = clip(PW'(r_hi) + w2, r_n);
                    end
                end
                o_ctrl.rd_sel = n_par;
            end
            S_EPREP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    o_ctrl.out_last = (r_i + CW'(1) == r_n);
                    n_i = r_i + CW'(1);
                    if (r_i + CW'(1) == r_n) begin
                        n_n     = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Reads are addressed with the next pointers so that the registered
    // read data matches the current pointers.
    assign o_rd_addr_a = n_i[AW-1:0];
    assign o_rd_addr_b = n_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_par   <= 1'b0;
            r_w     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
            r_par   <= n_par;
            r_w     <= n_w;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
        end
    end

endmodule

// ----- hw/rtl/merge_sorter.sv -----
// Merge sorter top level: ascending, stable sort of up to MAX_ITEMS signed
// words. Depends on msort_pkg, msort_ctrl and msort_dp.
//
// Usage: words of a set arrive on the s_axis channel, the final word of the
// set marked by s_axis_tlast. Loading takes one word per cycle. Words beyond
// MAX_ITEMS are dropped; every result of such a set then carries tuser = 1.
// After the final word the sequencer runs ceil(log2(n)) merge passes, each
// priming the read port and then moving one word per cycle through the
// compare and the store write port, then primes the read port once more and
// emits the sorted words on m_axis at one per cycle while m_axis_tready
// allows, tlast on the final one.
// s_axis_tready is high only while a set is loading; it rises again once the
// last result has entered the output register, so loading of the next set
// overlaps the hand-off of that result. A stall on m_axis_tready holds the
// emit pass in place; nothing is lost. Reset (synchronous, active low)
// empties the set and the output register.
module merge_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [msort_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic                          s_axis_tlast,  // last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [msort_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] value_res
    output logic                          m_axis_tlast,  // last_res
    output logic                          m_axis_tuser   // [0] overflow
);
    import msort_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_ms_ctrl      ctrl;
    t_ms_stat      stat;
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

    msort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_last   (s_axis_tlast),
        .o_ctrl      (ctrl),
        .i_stat      (stat),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b)
    );

    msort_dp #(
        .AW (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_wr_addr   (wr_addr),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_in_value  (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

// ----- tb/tb_merge_sorter.sv -----
// Self-checking testbench for merge_sorter: sends sets of signed words on the
// input stream, predicts the sorted output and checks every result word.
// Depends on msort_pkg and the merge_sorter RTL.
module tb_merge_sorter;

    import msort_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 160;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               ovf;
    } t_sorted_word;

    // Shapes of value used by the random sets.
    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_MIXED
    } t_value_shape;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata;   // [31:0] value
    logic               s_axis_tlast;   // last
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;   // [31:0] value_res
    logic               m_axis_tlast;   // last_res
    logic               m_axis_tuser;   // [0] overflow

    // Words of the set being loaded, as the block should hold them.
    logic signed [VALUE_W-1:0] set_words [CAPACITY];
    int                        set_len;
    logic                      set_lost;

    t_sorted_word sorted_q[$];

    int  words_sent;
    int  sets_sent;
    int  overflow_sets;
    int  results_checked;
    int  mismatches;
    int  idle_cycles;
    int  hold_request;
    bit  calm;

    merge_sorter #(
        .MAX_ITEMS(CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Stable insertion sort of the collected set; the sorted words go to the
    // expected queue and the set starts over.
    function automatic void close_set();
        logic signed [VALUE_W-1:0] key;
        int                        j;
        for (int i = 1; i < set_len; i++) begin
            key = set_words[i];
            j = i - 1;
            while (j >= 0 && set_words[j] > key) begin
                set_words[j + 1] = set_words[j];
                j--;
            end
            set_words[j + 1] = key;
        end
        for (int i = 0; i < set_len; i++) begin
            sorted_q.push_back('{value: set_words[i], last: (i == set_len - 1),
                                 ovf: set_lost});
        end
        if (set_lost) begin
            overflow_sets++;
        end
        sets_sent++;
        set_len  = 0;
        set_lost = 1'b0;
    endfunction

    function automatic void accept_word(logic [VALUE_W-1:0] v, logic lst);
        if (set_len < CAPACITY) begin
            set_words[set_len] = v;
            set_len++;
        end else begin
            set_lost = 1'b1;
        end
        words_sent++;
        if (lst) begin
            close_set();
        end
    endfunction

    // Offers one word, after a random gap (none while calm), and waits for the handshake.
    // Valid is left high afterwards so that back-to-back words keep it high.
    task automatic send_word(logic [VALUE_W-1:0] v, logic lst);
        while (!calm && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= $urandom_range(1);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= lst;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        accept_word(v, lst);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word(t_value_shape shape);
        case (shape)
            VAL_NARROW:  pick_word = $urandom_range(8) - 4;
            VAL_EXTREME: begin
                case ($urandom_range(3))
                    0:       pick_word = 32'h8000_0000;
                    1:       pick_word = 32'h7fff_ffff;
                    2:       pick_word = 32'hffff_ffff;
                    default: pick_word = 32'h0000_0000;
                endcase
            end
            VAL_MIXED:   pick_word = ($urandom_range(1) != 0) ? $urandom
                                                              : $urandom_range(8) - 4;
            default:     pick_word = $urandom;
        endcase
    endfunction

    task automatic send_random_set(int len);
        t_value_shape shape;
        shape = t_value_shape'($urandom_range(3));
        for (int i = 0; i < len; i++) begin
            send_word(pick_word(shape), i == len - 1);
        end
    endtask

    task automatic test_directed();
        logic [VALUE_W-1:0] extremes [7];
        extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1,
                     32'h8000_0000, 32'h7fff_ffff};
        foreach (extremes[i]) begin
            send_word(extremes[i], i == 6);
        end
        // A set of one word, equal words, an ordered and a reversed set.
        send_word(32'd5, 1'b1);
        send_word(-32'sd7, 1'b0);
        send_word(-32'sd7, 1'b1);
        for (int i = 1; i <= 3; i++) begin
            send_word(i, i == 3);
        end
        for (int i = 3; i >= 1; i--) begin
            send_word(i, i == 1);
        end
    endtask

    // A full set, then two sets that lose words, both with the final word itself
    // dropped, then a small set to see the flag cleared.
    task automatic test_overflow();
        send_random_set(CAPACITY);
        for (int i = 0; i < CAPACITY + 2; i++) begin
            send_word($urandom, i == CAPACITY + 1);
        end
        for (int i = 0; i < CAPACITY + 5; i++) begin
            send_word(pick_word(VAL_MIXED), i == CAPACITY + 4);
        end
        send_random_set(2);
    endtask

    // The receiver holds off while several sets are offered, so the block
    // fills and stops taking words.
    task automatic test_backpressure();
        hold_request = 400;
        for (int s = 0; s < 4; s++) begin
            send_random_set($urandom_range(12, 3));
        end
    endtask

    task automatic test_random_sets();
        int start;
        int pick;
        int len;
        int set_idx;
        start   = words_sent;
        set_idx = 0;
        while (words_sent - start < RANDOM_ITEMS) begin
            calm = (set_idx >= 2 && set_idx < 10);
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(8, 1);
            else if (pick < 90) len = $urandom_range(32, 9);
            else if (pick < 97) len = $urandom_range(CAPACITY, 33);
            else                len = $urandom_range(CAPACITY + 6, CAPACITY + 1);
            send_random_set(len);
            set_idx++;
        end
        calm = 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        static int hold_left = 0;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result word: value %h last %b ovf %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end else begin
                want = sorted_q.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch: expected value %h last %b ovf %b, %s",
                                 results_checked, want.value, want.last, want.ovf,
                                 $sformatf("got value %h last %b ovf %b",
                                           m_axis_tdata, m_axis_tlast, m_axis_tuser));
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither stream moves a word.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d results pending",
                     idle_cycles, sorted_q.size());
            $display("tb_merge_sorter: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        set_len         = 0;
        set_lost        = 1'b0;
        words_sent      = 0;
        sets_sent       = 0;
        overflow_sets   = 0;
        results_checked = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        hold_request    = 0;
        calm            = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_random_sets();

        s_axis_tvalid <= 1'b0;
        while (sorted_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        $display("%0d words in %0d sets sent, %0d of them overflowing; %0d results checked",
                 words_sent, sets_sent, overflow_sets, results_checked);
        $display("%0d mismatches, %0d results still expected", mismatches, sorted_q.size());
        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("tb_merge_sorter: PASS");
        end else begin
            $display("tb_merge_sorter: FAIL");
        end
        $finish;
    end

endmodule
